// ===== rtl/wnllr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wnllr_pkg;

  // Widths of the stream fields.
  localparam int unsigned ValW   = 32;
  localparam int unsigned SumW   = 48;
  localparam int unsigned ClassW = 8;
  localparam int unsigned TgtW   = 16;

  // Saturation limits of the Q(48-F).F sums.
  localparam logic [SumW-1:0] Max48 = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] Min48 = {1'b1, {(SumW-1){1'b0}}};

  // Reduction modes; any other code behaves as the mean.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SUM  = 2'd1;
  localparam logic [1:0] MODE_MEAN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_REDUCTION_MODE    = 2'd0;
  localparam logic [1:0] REG_IGNORE_CLASS      = 2'd1;
  localparam logic [1:0] REG_USE_CLASS_WEIGHTS = 2'd2;

  // Input item kinds.
  localparam logic KIND_WEIGHT  = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  // Sequencer of the mean divider.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  // Request toward the mean divider.
  typedef struct packed {
    logic            start;
    logic            ack;
    logic            neg;
    logic [SumW-1:0] magnitude;
    logic [SumW-1:0] divisor;
  } div_req_t;

  // Answer of the mean divider.
  typedef struct packed {
    logic            done;
    logic            sat;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/wnllr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider for the mean: one quotient bit per cycle.
// Gives floor(|a| * 2^F / b) with the sign of a, clamped to 48 bits.
module wnllr_div #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wnllr_pkg::div_req_t req_i,
  output wnllr_pkg::div_rsp_t rsp_o
);

  localparam int unsigned SumW = wnllr_pkg::SumW;
  localparam int unsigned NumW = SumW + FRACTION_BITS;
  localparam int unsigned CntW = $clog2(NumW);
  localparam int unsigned HiW  = NumW - (SumW - 1);

  wnllr_pkg::div_state_e state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [NumW-1:0]       num_q, num_d;
  logic [NumW-1:0]       quo_q, quo_d;
  logic [SumW:0]         rem_q, rem_d;
  logic [SumW-1:0]       den_q, den_d;
  logic                  neg_q, neg_d;

  logic [SumW:0]         rem_shift;
  logic                  fits;
  logic [HiW-1:0]        quo_hi;
  logic                  sat_pos;
  logic                  sat_neg;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wnllr_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // One restoring step: shift in the next dividend bit and try the subtraction.
  assign rem_shift = {rem_q[SumW-1:0], num_q[NumW-1]};
  assign fits      = rem_shift >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    case (state_q)
      wnllr_pkg::DIV_IDLE: begin
        if (req_i.start) begin
          num_d   = {req_i.magnitude, {FRACTION_BITS{1'b0}}};
          quo_d   = '0;
          rem_d   = '0;
          den_d   = req_i.divisor;
          neg_d   = req_i.neg;
          cnt_d   = CntW'(NumW - 1);
          state_d = wnllr_pkg::DIV_RUN;
        end
      end
      wnllr_pkg::DIV_RUN: begin
        num_d = {num_q[NumW-2:0], 1'b0};
        quo_d = {quo_q[NumW-2:0], fits};
        rem_d = fits ? (rem_shift - {1'b0, den_q}) : rem_shift;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = wnllr_pkg::DIV_DONE;
        end
      end
      wnllr_pkg::DIV_DONE: begin
        if (req_i.ack) begin
          state_d = wnllr_pkg::DIV_IDLE;
        end
      end
      default: begin
        state_d = wnllr_pkg::DIV_IDLE;
      end
    endcase
  end

  // A positive result clamps at 2^47 and above; a negative one only beyond 2^47.
  assign quo_hi  = quo_q[NumW-1:SumW-1];
  assign sat_pos = quo_hi != '0;
  assign sat_neg = (quo_hi > HiW'(1)) || ((quo_hi == HiW'(1)) && (quo_q[SumW-2:0] != '0));

  always_comb begin
    rsp_o.done = state_q == wnllr_pkg::DIV_DONE;
    if (neg_q) begin
      rsp_o.sat      = sat_neg;
      rsp_o.quotient = sat_neg ? wnllr_pkg::Min48 : (SumW'(0) - quo_q[SumW-1:0]);
    end else begin
      rsp_o.sat      = sat_pos;
      rsp_o.quotient = sat_pos ? wnllr_pkg::Max48 : quo_q[SumW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/weighted_nll_loss_reduce_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Class-weighted negative log-likelihood loss with none, sum and mean reduction.
// Row elements stream in one beat per cycle unless a busy divider or a stalled
// result holds off the input; a weight beat (kind 0) writes the class weight
// table, an element beat whose class matches the row target forms -w*x in
// Q(48-F).F. Results pass the s1, s2, s3 and output registers in that order.
// The weight table is a single-port synchronous RAM read at accept, followed by
// a multiply stage, a round-and-clamp stage and a row/sum update stage. A final
// mean result with a positive weight total runs a bit-serial divider, during
// which the input is held off. Unloaded table entries read as undefined.
module weighted_nll_loss_reduce_unit #(
  parameter int unsigned CLASSES       = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration write channel.
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  // Input stream.
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: class_index[7:0], sample_value[39:8], target_class[55:40]
  input  wire  [55:0] s_axis_tdata_i,
  // tuser: kind[0], row_end[1]
  input  wire  [1:0]  s_axis_tuser_i,
  // tlast: stream_end
  input  wire         s_axis_tlast_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // tdata: loss[47:0], weight_total[95:48]
  output logic [95:0] m_axis_tdata_o,
  // tuser: is_final[0], row_skipped[1], saturated[2]
  output logic [2:0]  m_axis_tuser_o
);

  localparam int unsigned ValW   = wnllr_pkg::ValW;
  localparam int unsigned SumW   = wnllr_pkg::SumW;
  localparam int unsigned ClassW = wnllr_pkg::ClassW;
  localparam int unsigned TgtW   = wnllr_pkg::TgtW;
  localparam int unsigned Depth  = (CLASSES < 256) ? CLASSES : 256;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned ProdW  = 2 * ValW;

  localparam logic [TgtW:0]     ClassLim = (TgtW + 1)'(CLASSES);
  localparam logic [ClassW:0]   DepthLim = (ClassW + 1)'(Depth);
  localparam logic [ValW-1:0]   WeightOne = ValW'(1) << FRACTION_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [1:0]             mode_q;
  logic signed [TgtW-1:0] ignore_q;
  logic                   use_w_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= wnllr_pkg::MODE_MEAN;
      ignore_q <= -16'sd100;
      use_w_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wnllr_pkg::REG_REDUCTION_MODE:    mode_q   <= cfg_data_i[1:0];
        wnllr_pkg::REG_IGNORE_CLASS:      ignore_q <= cfg_data_i;
        wnllr_pkg::REG_USE_CLASS_WEIGHTS: use_w_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input beat fields.
  logic                   in_kind;
  logic [ClassW-1:0]      in_cls;
  logic [ValW-1:0]        in_x;
  logic [TgtW-1:0]        in_tgt;
  logic                   in_row_end;
  logic                   in_stream_end;
  logic                   adv;
  logic                   accept;

  assign in_cls        = s_axis_tdata_i[7:0];
  assign in_x          = s_axis_tdata_i[39:8];
  assign in_tgt        = s_axis_tdata_i[55:40];
  assign in_kind       = s_axis_tuser_i[0];
  assign in_row_end    = s_axis_tuser_i[1];
  assign in_stream_end = s_axis_tlast_i;

  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  // ---------------------------------------------------------------------------
  // Class weight table: written by weight beats, read for every accepted beat.
  logic [ValW-1:0] weight_mem [Depth];
  logic [ValW-1:0] rd_q;
  logic            wr_en;

  assign wr_en = accept && (in_kind == wnllr_pkg::KIND_WEIGHT) && ({1'b0, in_cls} < DepthLim);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      weight_mem[in_cls[IdxW-1:0]] <= in_x;
    end
    if (adv) begin
      rd_q <= weight_mem[in_cls[IdxW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: table data arrives; decide the match and multiply.
  logic                   s1_valid_q;
  logic [ClassW-1:0]      s1_cls_q;
  logic signed [ValW-1:0] s1_x_q;
  logic [TgtW-1:0]        s1_tgt_q;
  logic                   s1_row_end_q;
  logic                   s1_stream_end_q;

  logic                   s1_match;
  logic signed [ValW-1:0] s1_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept && (in_kind == wnllr_pkg::KIND_ELEMENT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cls_q        <= in_cls;
      s1_x_q          <= in_x;
      s1_tgt_q        <= in_tgt;
      s1_row_end_q    <= in_row_end;
      s1_stream_end_q <= in_stream_end;
    end
  end

  // The target must differ from the ignore class, lie in range and name this column.
  assign s1_match = (s1_tgt_q != ignore_q) && !s1_tgt_q[TgtW-1] &&
                    ({1'b0, s1_tgt_q} < ClassLim) &&
                    (s1_tgt_q[TgtW-1:ClassW] == '0) && (s1_tgt_q[ClassW-1:0] == s1_cls_q);
  assign s1_w     = use_w_q ? rd_q : WeightOne;

  // ---------------------------------------------------------------------------
  // Stage 2: registered product.
  logic                    s2_valid_q;
  logic                    s2_match_q;
  logic signed [ValW-1:0]  s2_w_q;
  logic signed [ProdW-1:0] s2_prod_q;
  logic                    s2_row_end_q;
  logic                    s2_stream_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_match_q      <= s1_match;
      s2_w_q          <= s1_w;
      s2_prod_q       <= s1_w * s1_x_q;
      s2_row_end_q    <= s1_row_end_q;
      s2_stream_end_q <= s1_stream_end_q;
    end
  end

  // Negate, shift right by F rounding toward minus infinity, clamp to 48 bits.
  logic signed [ProdW:0]  s2_neg;
  logic signed [ProdW:0]  s2_shift;
  logic                   s2_sat;
  logic [SumW-1:0]        s2_term;

  assign s2_neg   = -$signed({s2_prod_q[ProdW-1], s2_prod_q});
  assign s2_shift = s2_neg >>> FRACTION_BITS;
  assign s2_sat   = (s2_shift[ProdW:SumW-1] != '0) && (s2_shift[ProdW:SumW-1] != '1);
  assign s2_term  = s2_sat ? (s2_shift[ProdW] ? wnllr_pkg::Min48 : wnllr_pkg::Max48)
                           : s2_shift[SumW-1:0];

  // ---------------------------------------------------------------------------
  // Stage 3: row and sum update.
  logic                   s3_valid_q;
  logic                   s3_match_q;
  logic signed [ValW-1:0] s3_w_q;
  logic [SumW-1:0]        s3_term_q;
  logic                   s3_psat_q;
  logic                   s3_row_end_q;
  logic                   s3_stream_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_match_q      <= s2_match_q;
      s3_w_q          <= s2_w_q;
      s3_term_q       <= s2_term;
      s3_psat_q       <= s2_sat;
      s3_row_end_q    <= s2_row_end_q;
      s3_stream_end_q <= s2_stream_end_q;
    end
  end

  // Row and stream state.
  logic [SumW-1:0]        row_term_q, row_term_d;
  logic signed [ValW-1:0] row_weight_q, row_weight_d;
  logic                   row_hit_q, row_hit_d;
  logic [SumW-1:0]        loss_sum_q, loss_sum_d;
  logic [SumW-1:0]        weight_sum_q, weight_sum_d;
  logic                   ovf_q, ovf_d;
  logic                   busy_q, busy_d;

  // Held fields of a final mean result while the divider runs.
  logic [SumW-1:0]        pend_weight_q, pend_weight_d;
  logic                   pend_skip_q, pend_skip_d;
  logic                   pend_ovf_q, pend_ovf_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [SumW-1:0]        out_loss_q, out_loss_d;
  logic [SumW-1:0]        out_weight_q, out_weight_d;
  logic                   out_final_q, out_final_d;
  logic                   out_skip_q, out_skip_d;
  logic                   out_sat_q, out_sat_d;

  logic                   out_free;
  logic                   s3_end;
  logic                   s3_needs_out;
  logic [SumW-1:0]        term_new;
  logic signed [ValW-1:0] w_new;
  logic                   hit_any;
  logic                   ovf_now;
  logic [SumW:0]          ls_add;
  logic [SumW:0]          ws_add;
  logic [SumW-1:0]        ls_new;
  logic [SumW-1:0]        ws_new;
  logic                   sum_sat;
  logic                   ws_pos;

  wnllr_pkg::div_req_t    div_req;
  wnllr_pkg::div_rsp_t    div_rsp;

  assign out_free     = !out_valid_q || m_axis_tready_i;
  assign s3_end       = s3_row_end_q || s3_stream_end_q;
  assign s3_needs_out = s3_valid_q && s3_end &&
                        ((mode_q == wnllr_pkg::MODE_NONE) || s3_stream_end_q);
  assign adv          = !busy_q && !(s3_needs_out && !out_free);

  // The last matching element of the row wins.
  assign term_new = s3_match_q ? s3_term_q : row_term_q;
  assign w_new    = s3_match_q ? s3_w_q : row_weight_q;
  assign hit_any  = s3_match_q || row_hit_q;
  assign ovf_now  = ovf_q || (s3_match_q && s3_psat_q);

  // Saturating sums over the rows that met their target.
  assign ls_add = {loss_sum_q[SumW-1], loss_sum_q} + {term_new[SumW-1], term_new};
  assign ws_add = {weight_sum_q[SumW-1], weight_sum_q} + (SumW + 1)'(w_new);

  always_comb begin
    sum_sat = 1'b0;
    ls_new  = loss_sum_q;
    ws_new  = weight_sum_q;
    if (hit_any) begin
      if (ls_add[SumW] != ls_add[SumW-1]) begin
        ls_new  = ls_add[SumW] ? wnllr_pkg::Min48 : wnllr_pkg::Max48;
        sum_sat = 1'b1;
      end else begin
        ls_new = ls_add[SumW-1:0];
      end
      if (ws_add[SumW] != ws_add[SumW-1]) begin
        ws_new  = ws_add[SumW] ? wnllr_pkg::Min48 : wnllr_pkg::Max48;
        sum_sat = 1'b1;
      end else begin
        ws_new = ws_add[SumW-1:0];
      end
    end
  end

  assign ws_pos = !ws_new[SumW-1] && (ws_new != '0);

  // Row update, reduction and result selection.
  always_comb begin
    row_term_d    = row_term_q;
    row_weight_d  = row_weight_q;
    row_hit_d     = row_hit_q;
    loss_sum_d    = loss_sum_q;
    weight_sum_d  = weight_sum_q;
    ovf_d         = ovf_q;
    busy_d        = busy_q;
    pend_weight_d = pend_weight_q;
    pend_skip_d   = pend_skip_q;
    pend_ovf_d    = pend_ovf_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_loss_d    = out_loss_q;
    out_weight_d  = out_weight_q;
    out_final_d   = out_final_q;
    out_skip_d    = out_skip_q;
    out_sat_d     = out_sat_q;

    div_req.start     = 1'b0;
    div_req.ack       = 1'b0;
    div_req.neg       = ls_new[SumW-1];
    div_req.magnitude = ls_new[SumW-1] ? (SumW'(0) - ls_new) : ls_new;
    div_req.divisor   = ws_new;

    if (adv && s3_valid_q) begin
      if (!s3_end) begin
        row_term_d   = term_new;
        row_weight_d = w_new;
        row_hit_d    = hit_any;
        ovf_d        = ovf_now;
      end else begin
        row_term_d   = '0;
        row_weight_d = '0;
        row_hit_d    = 1'b0;
        if (mode_q == wnllr_pkg::MODE_NONE) begin
          // One result per row.
          out_valid_d  = 1'b1;
          out_loss_d   = hit_any ? term_new : '0;
          out_weight_d = '0;
          out_final_d  = 1'b0;
          out_skip_d   = !hit_any;
          out_sat_d    = ovf_now;
          ovf_d        = 1'b0;
        end else if (!s3_stream_end_q) begin
          loss_sum_d   = ls_new;
          weight_sum_d = ws_new;
          ovf_d        = ovf_now || sum_sat;
        end else begin
          // Stream end: the sums restart and the flag clears.
          loss_sum_d   = '0;
          weight_sum_d = '0;
          ovf_d        = 1'b0;
          if ((mode_q != wnllr_pkg::MODE_SUM) && ws_pos) begin
            div_req.start = 1'b1;
            busy_d        = 1'b1;
            pend_weight_d = ws_new;
            pend_skip_d   = !hit_any;
            pend_ovf_d    = ovf_now || sum_sat;
          end else begin
            out_valid_d  = 1'b1;
            out_loss_d   = (mode_q == wnllr_pkg::MODE_SUM) ? ls_new : '0;
            out_weight_d = ws_new;
            out_final_d  = 1'b1;
            out_skip_d   = !hit_any;
            out_sat_d    = ovf_now || sum_sat;
          end
        end
      end
    end

    // Quotient ready: hand the final mean result to the output register.
    if (busy_q && div_rsp.done && out_free) begin
      div_req.ack  = 1'b1;
      busy_d       = 1'b0;
      out_valid_d  = 1'b1;
      out_loss_d   = div_rsp.quotient;
      out_weight_d = pend_weight_q;
      out_final_d  = 1'b1;
      out_skip_d   = pend_skip_q;
      out_sat_d    = pend_ovf_q || div_rsp.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_term_q   <= '0;
      row_weight_q <= '0;
      row_hit_q    <= 1'b0;
      loss_sum_q   <= '0;
      weight_sum_q <= '0;
      ovf_q        <= 1'b0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      row_term_q   <= row_term_d;
      row_weight_q <= row_weight_d;
      row_hit_q    <= row_hit_d;
      loss_sum_q   <= loss_sum_d;
      weight_sum_q <= weight_sum_d;
      ovf_q        <= ovf_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_weight_q <= pend_weight_d;
    pend_skip_q   <= pend_skip_d;
    pend_ovf_q    <= pend_ovf_d;
    out_loss_q    <= out_loss_d;
    out_weight_q  <= out_weight_d;
    out_final_q   <= out_final_d;
    out_skip_q    <= out_skip_d;
    out_sat_q     <= out_sat_d;
  end

  // Mean divider.
  wnllr_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Result beat.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_weight_q, out_loss_q};
  assign m_axis_tuser_o  = {out_sat_q, out_skip_q, out_final_q};

endmodule

`default_nettype wire
